// ----- hw/rtl/altpid_pkg.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// altpid_pkg
// Shared widths, register indexes, reset values and unit status type for the
// altitude PID controller.
// -----------------------------------------------------------------------------
package altpid_pkg;

  // Field and datapath widths
  localparam int unsigned GAIN_W    = 8;   // gains and step time
  localparam int unsigned LIM_W     = 15;  // integrator clamp magnitude
  localparam int unsigned DRV_W     = 7;   // drive, bounds, target height
  localparam int unsigned ALT_W     = 8;   // measured altitude
  localparam int unsigned ERR_W     = 9;   // target minus altitude, signed
  localparam int unsigned DIFF_W    = 10;  // error difference and derivative, signed
  localparam int unsigned ACC_W     = 16;  // clamped integrator, signed
  localparam int unsigned SUM_W     = 18;  // integrator before the clamp, signed
  localparam int unsigned CMD_W     = 25;  // PID command, signed
  localparam int unsigned DSUM_W    = 26;  // command plus drive offset, signed

  // Serial multiplier: signed multiplicand times unsigned 8-bit multiplier
  localparam int unsigned MUL_AW    = ACC_W;
  localparam int unsigned MUL_BW    = GAIN_W;
  localparam int unsigned MUL_PW    = MUL_AW + MUL_BW;

  // Stream widths
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 48;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = LIM_W;

  // Target height limits and step default
  localparam logic [DRV_W-1:0] TARGET_MAX   = 7'd100;
  localparam logic [DRV_W-1:0] TARGET_RESET = 7'd50;
  localparam int unsigned      HEIGHT_STEP_DEF = 10;

  // Configuration reset values
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 8'd1;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 8'd0;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 8'd1;
  localparam logic [LIM_W-1:0]  INTEG_LIM_RST  = 15'd100;
  localparam logic [GAIN_W-1:0] STEP_TIME_RST  = 8'd1;
  localparam logic [DRV_W-1:0]  DRIVE_MID_RST  = 7'd50;
  localparam logic [DRV_W-1:0]  DRIVE_MIN_RST  = 7'd0;
  localparam logic [DRV_W-1:0]  DRIVE_MAX_RST  = 7'd100;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INTEG_GAIN = 3'd1,
    REG_DERIV_GAIN = 3'd2,
    REG_INTEG_LIM  = 3'd3,
    REG_STEP_TIME  = 3'd4,
    REG_DRIVE_MID  = 3'd5,
    REG_DRIVE_MIN  = 3'd6,
    REG_DRIVE_MAX  = 3'd7
  } cfg_reg_e;

  // Input item kinds
  localparam logic ACT_BUTTON = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  // Status of a serial arithmetic unit
  typedef struct packed {
    logic busy;  // iterating
    logic done;  // result ready, one-cycle pulse
  } unit_stat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/altitude_pid_with_target_stepping.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// altitude_pid_with_target_stepping
// Integer PID altitude controller with a button-stepped target height.
//
//   Channel   Dir  Handshake                       Payload
//   s_axis    in   tvalid/tready                   tuser: action; tdata: button_dir, altitude
//   m_axis    out  tvalid/tready                   tdata: drive, raw_command, height_err,
//                                                         target_now
//   cfg       in   cfg_we_i, no wait               cfg_idx_i selects, cfg_wdata_i value
//
// A button item is taken without leaving idle and gives no result. A sample
// item runs four bit-serial multiplies on one shared multiplier plus one clamp
// and one output step; the next item is taken only once the result is in the
// output register. The derivative divider starts with the first multiply and
// runs alongside it. Reset clears the control state, integrator and last error,
// loads the target and register defaults; payload and output data are not
// reset. A stalled result waits in the output register while the next item is
// taken and worked on.
// -----------------------------------------------------------------------------
module altitude_pid_with_target_stepping #(
  parameter int unsigned HeightStep = altpid_pkg::HEIGHT_STEP_DEF
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  // configuration write port
  input  wire logic                                    cfg_we_i,
  input  wire logic [altpid_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [altpid_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  // input items
  input  wire logic                                    s_axis_tvalid,
  output logic                                         s_axis_tready,
  // [0] button_dir, [8:1] altitude, [15:9] zero
  input  wire logic [altpid_pkg::IN_DATA_W-1:0]        s_axis_tdata,
  // [0] action
  input  wire logic                                    s_axis_tuser,
  // result items
  output logic                                         m_axis_tvalid,
  input  wire logic                                    m_axis_tready,
  // [6:0] drive, [31:7] raw_command, [40:32] height_err, [47:41] target_now
  output logic [altpid_pkg::OUT_DATA_W-1:0]            m_axis_tdata
);
  import altpid_pkg::*;

  localparam logic [DRV_W:0] StepV = (DRV_W+1)'(HeightStep);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MDT  = 7'b0000010,
    ST_ACC  = 7'b0000100,
    ST_MP   = 7'b0001000,
    ST_MI   = 7'b0010000,
    ST_MD   = 7'b0100000,
    ST_DRV  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [GAIN_W-1:0] prop_gain_q, integ_gain_q, deriv_gain_q, step_time_q;
  logic [LIM_W-1:0]  integ_lim_q;
  logic [DRV_W-1:0]  drive_mid_q, drive_min_q, drive_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q  <= PROP_GAIN_RST;
      integ_gain_q <= INTEG_GAIN_RST;
      deriv_gain_q <= DERIV_GAIN_RST;
      integ_lim_q  <= INTEG_LIM_RST;
      step_time_q  <= STEP_TIME_RST;
      drive_mid_q  <= DRIVE_MID_RST;
      drive_min_q  <= DRIVE_MIN_RST;
      drive_max_q  <= DRIVE_MAX_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_PROP_GAIN:  prop_gain_q  <= cfg_wdata_i[GAIN_W-1:0];
        REG_INTEG_GAIN: integ_gain_q <= cfg_wdata_i[GAIN_W-1:0];
        REG_DERIV_GAIN: deriv_gain_q <= cfg_wdata_i[GAIN_W-1:0];
        REG_INTEG_LIM:  integ_lim_q  <= cfg_wdata_i[LIM_W-1:0];
        REG_STEP_TIME:  step_time_q  <= cfg_wdata_i[GAIN_W-1:0];
        REG_DRIVE_MID:  drive_mid_q  <= cfg_wdata_i[DRV_W-1:0];
        REG_DRIVE_MIN:  drive_min_q  <= cfg_wdata_i[DRV_W-1:0];
        REG_DRIVE_MAX:  drive_max_q  <= cfg_wdata_i[DRV_W-1:0];
        default: ;
      endcase
    end
  end

  // Input field unpack
  logic              in_dir;
  logic [ALT_W-1:0]  in_alt;
  logic              in_acc;

  assign in_dir = s_axis_tdata[0];
  assign in_alt = s_axis_tdata[ALT_W:1];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // Controller state and per-sample working registers
  logic [DRV_W-1:0]        target_q;
  logic signed [ACC_W-1:0] integ_acc_q;
  logic signed [ERR_W-1:0] last_err_q;
  logic signed [ERR_W-1:0] err_q;
  logic [DRV_W-1:0]        tgt_now_q;
  logic [GAIN_W-1:0]       dt_q;
  logic signed [CMD_W-1:0] cmd_q;
  logic                    launch_q;

  // Shared serial units
  logic signed [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0]        mul_b;
  logic signed [MUL_PW-1:0] mul_prod;
  unit_stat_t               mul_stat, div_stat;
  logic                     mul_start, div_start;
  logic signed [DIFF_W-1:0] div_dvd, div_quo;

  // Launch a multiply once per state; the derivative multiply waits for the divider
  assign mul_start = launch_q && !(state_q == ST_MD && div_stat.busy);
  assign div_start = launch_q && (state_q == ST_MDT);
  assign div_dvd   = DIFF_W'(err_q) - DIFF_W'(last_err_q);

  // Select multiply operands per step
  always_comb begin
    unique case (state_q)
      ST_MDT: begin
        mul_a = MUL_AW'(err_q);
        mul_b = dt_q;
      end
      ST_MP: begin
        mul_a = MUL_AW'(err_q);
        mul_b = prop_gain_q;
      end
      ST_MI: begin
        mul_a = integ_acc_q;
        mul_b = integ_gain_q;
      end
      ST_MD: begin
        mul_a = MUL_AW'(div_quo);
        mul_b = deriv_gain_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  altpid_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (mul_a),
    .mplier_i (mul_b),
    .prod_o   (mul_prod),
    .stat_o   (mul_stat)
  );

  altpid_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvd_i   (div_dvd),
    .dvs_i   (dt_q),
    .quo_o   (div_quo),
    .stat_o  (div_stat)
  );

  // Target stepping, clamped to the height range
  logic [DRV_W:0]   tgt_ext, tgt_up;
  logic [DRV_W-1:0] tgt_next;

  assign tgt_ext = {1'b0, target_q};
  assign tgt_up  = tgt_ext + StepV;

  always_comb begin
    if (in_dir) begin
      tgt_next = (tgt_up > {1'b0, TARGET_MAX}) ? TARGET_MAX : tgt_up[DRV_W-1:0];
    end else begin
      tgt_next = (tgt_ext < StepV) ? '0 : DRV_W'(tgt_ext - StepV);
    end
  end

  // Integrator update and clamp
  logic signed [SUM_W-1:0] acc_sum, lim_pos, lim_neg, acc_clamped;

  assign acc_sum = SUM_W'(integ_acc_q) + SUM_W'(mul_prod);
  assign lim_pos = $signed(SUM_W'(integ_lim_q));
  assign lim_neg = -lim_pos;

  always_comb begin
    if (acc_sum > lim_pos) begin
      acc_clamped = lim_pos;
    end else if (acc_sum < lim_neg) begin
      acc_clamped = lim_neg;
    end else begin
      acc_clamped = acc_sum;
    end
  end

  // Drive: offset the command, test the upper bound first
  logic signed [DSUM_W-1:0] drv_sum;
  logic [DRV_W-1:0]         drive;

  assign drv_sum = $signed(DSUM_W'(drive_mid_q)) + DSUM_W'(cmd_q);

  always_comb begin
    if (drv_sum > $signed(DSUM_W'(drive_max_q))) begin
      drive = drive_max_q;
    end else if (drv_sum < $signed(DSUM_W'(drive_min_q))) begin
      drive = drive_min_q;
    end else begin
      drive = drv_sum[DRV_W-1:0];
    end
  end

  logic out_free;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc && s_axis_tuser == ACT_SAMPLE) state_d = ST_MDT;
      ST_MDT:  if (mul_stat.done) state_d = ST_ACC;
      ST_ACC:  state_d = ST_MP;
      ST_MP:   if (mul_stat.done) state_d = ST_MI;
      ST_MI:   if (mul_stat.done) state_d = ST_MD;
      ST_MD:   if (mul_stat.done) state_d = ST_DRV;
      ST_DRV:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control and controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      launch_q      <= 1'b0;
      target_q      <= TARGET_RESET;
      integ_acc_q   <= '0;
      last_err_q    <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state_q <= state_d;
      // arm a launch on entry to each multiply step, drop it once issued
      if ((state_q == ST_IDLE && state_d == ST_MDT) || state_q == ST_ACC ||
          (mul_stat.done && (state_q == ST_MP || state_q == ST_MI))) begin
        launch_q <= 1'b1;
      end else if (mul_start) begin
        launch_q <= 1'b0;
      end
      if (in_acc && s_axis_tuser == ACT_BUTTON) begin
        target_q <= tgt_next;
      end
      if (state_q == ST_ACC) begin
        integ_acc_q <= ACC_W'(acc_clamped);
        last_err_q  <= err_q;
      end
      if (state_q == ST_DRV && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Sample payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tuser == ACT_SAMPLE) begin
      err_q     <= ERR_W'({2'b00, target_q}) - ERR_W'({1'b0, in_alt});
      tgt_now_q <= target_q;
      dt_q      <= (step_time_q == '0) ? GAIN_W'(1) : step_time_q;
    end
    // accumulate the command terms as each product lands
    if (state_q == ST_ACC) begin
      cmd_q <= '0;
    end else if (mul_stat.done && (state_q == ST_MP || state_q == ST_MI ||
                                   state_q == ST_MD)) begin
      cmd_q <= cmd_q + CMD_W'(mul_prod);
    end
    if (state_q == ST_DRV && out_free) begin
      m_axis_tdata <= {tgt_now_q, err_q, cmd_q, drive};
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/altpid_mul.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// altpid_mul
// Bit-serial shift-add multiplier: signed multiplicand times unsigned
// multiplier, one multiplier bit per cycle.
// -----------------------------------------------------------------------------
module altpid_mul (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start_i,
  input  wire logic signed [altpid_pkg::MUL_AW-1:0]  mcand_i,
  input  wire logic        [altpid_pkg::MUL_BW-1:0]  mplier_i,
  output logic signed      [altpid_pkg::MUL_PW-1:0]  prod_o,
  output altpid_pkg::unit_stat_t                     stat_o
);
  import altpid_pkg::*;

  localparam int unsigned CntW = $clog2(MUL_BW);
  localparam logic [CntW-1:0] CntLast = CntW'(MUL_BW - 1);

  logic                     busy_q, done_q;
  logic [CntW-1:0]          cnt_q;
  logic signed [MUL_PW-1:0] mcand_q, prod_q;
  logic [MUL_BW-1:0]        mplier_q;

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntLast) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift-add datapath: add the shifted multiplicand where the multiplier bit is set
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q  <= MUL_PW'(mcand_i);
      mplier_q <= mplier_i;
      prod_q   <= '0;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        prod_q <= prod_q + mcand_q;
      end
      mcand_q  <= mcand_q <<< 1;
      mplier_q <= mplier_q >> 1;
    end
  end

  assign prod_o      = prod_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule
`default_nettype wire

// ----- hw/rtl/altpid_div.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// altpid_div
// Restoring divider, one quotient bit per cycle. Signed dividend over an
// unsigned nonzero divisor, quotient truncated toward zero.
// -----------------------------------------------------------------------------
module altpid_div (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start_i,
  input  wire logic signed [altpid_pkg::DIFF_W-1:0]  dvd_i,
  input  wire logic        [altpid_pkg::GAIN_W-1:0]  dvs_i,
  output logic signed      [altpid_pkg::DIFF_W-1:0]  quo_o,
  output altpid_pkg::unit_stat_t                     stat_o
);
  import altpid_pkg::*;

  localparam int unsigned CntW = $clog2(DIFF_W);
  localparam logic [CntW-1:0] CntLast = CntW'(DIFF_W - 1);

  logic              busy_q, done_q;
  logic [CntW-1:0]   cnt_q;
  logic              neg_q;
  logic [DIFF_W-1:0] mag_q;    // dividend bits shift out, quotient bits shift in
  logic [GAIN_W-1:0] rem_q, dvs_q;
  logic [GAIN_W:0]   trial;
  logic              fits;

  // Shift in the next dividend bit and test the divisor against it
  assign trial = {rem_q, mag_q[DIFF_W-1]};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntLast) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Divide magnitudes, keep the sign apart
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dvd_i[DIFF_W-1];
      mag_q <= dvd_i[DIFF_W-1] ? DIFF_W'(-dvd_i) : DIFF_W'(dvd_i);
      rem_q <= '0;
      dvs_q <= dvs_i;
    end else if (busy_q) begin
      rem_q <= fits ? GAIN_W'(trial - {1'b0, dvs_q}) : trial[GAIN_W-1:0];
      mag_q <= {mag_q[DIFF_W-2:0], fits};
    end
  end

  assign quo_o       = neg_q ? -$signed(mag_q) : $signed(mag_q);
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule
`default_nettype wire

// ----- tb/tb_altitude_pid_with_target_stepping.sv -----
// -----------------------------------------------------------------------------
// tb_altitude_pid_with_target_stepping
// Self-checking bench for the altitude PID controller. An in-bench model keeps
// its own target height, integrator and last error, predicts every sample
// result and compares it field by field with the m_axis output. Directed
// items cover target clamping, zero step time, inverted drive bounds and
// extreme gains; random phases then vary configuration, input gaps and
// output stalls.
// -----------------------------------------------------------------------------
module tb_altitude_pid_with_target_stepping;
  timeunit 1ns;
  timeprecision 1ps;

  import altpid_pkg::*;

  localparam int HALF_PERIOD    = 5;
  localparam int SETTLE_CYCLES  = 60;    // longer than a sample takes to complete
  localparam int HOLD_CYCLES    = 400;   // long output stall
  localparam int QUIET_LIMIT    = 3000;  // cycles without any handshake
  localparam int REPORT_MAX     = 10;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 150;
  localparam int STEP           = HEIGHT_STEP_DEF;

  // Result fields, highest first so the struct matches the tdata layout
  typedef struct packed {
    logic [DRV_W-1:0]        target_now;
    logic signed [ERR_W-1:0] height_err;
    logic signed [CMD_W-1:0] raw_command;
    logic [DRV_W-1:0]        drive;
  } pid_out_t;

  typedef enum int {RDY_ALWAYS, RDY_RANDOM, RDY_PATTERN} rdy_mode_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // [0] button_dir, [8:1] altitude, [15:9] zero
  logic                  s_axis_tuser;   // [0] action
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // [6:0] drive, [31:7] raw_command,
                                         // [40:32] height_err, [47:41] target_now

  // Controller state and register copies kept by the bench
  int tgt_height;
  int integ_sum;
  int prev_err;
  int p_gain, i_gain, d_gain, acc_lim, tick, mid, dmin, dmax;

  pid_out_t  drive_expect_q[$];
  int        fail_count;
  int        quiet_cycles;
  int        burst_left;
  int        gap_max;
  bit        hold_req;
  rdy_mode_e rdy_mode;

  altitude_pid_with_target_stepping #(
    .HeightStep(STEP)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Clock
  initial clk_i = 1'b0;
  always #HALF_PERIOD clk_i = ~clk_i;

  // Step the target height on a button item
  function automatic void step_target(input logic up);
    if (up) begin
      tgt_height = tgt_height + STEP;
      if (tgt_height > int'(TARGET_MAX)) tgt_height = int'(TARGET_MAX);
    end else begin
      tgt_height = tgt_height - STEP;
      if (tgt_height < 0) tgt_height = 0;
    end
  endfunction

  // Advance the PID state on a sample item and form its result
  function automatic pid_out_t predict_sample(input logic [ALT_W-1:0] alt);
    int       dt;
    int       err;
    int       sum;
    int       deriv;
    int       cmd;
    int       drv;
    pid_out_t res;
    dt  = (tick == 0) ? 1 : tick;
    err = tgt_height - int'(alt);
    // integrate and clamp symmetrically
    sum = integ_sum + err * dt;
    if (sum > acc_lim) sum = acc_lim;
    if (sum < -acc_lim) sum = -acc_lim;
    integ_sum = sum;
    // signed divide truncates toward zero
    deriv    = (err - prev_err) / dt;
    prev_err = err;
    cmd = p_gain * err + i_gain * integ_sum + d_gain * deriv;
    // upper bound wins; lower bound only applies when not above it
    drv = mid + cmd;
    if (drv > dmax) begin
      drv = dmax;
    end else if (drv < dmin) begin
      drv = dmin;
    end
    res.drive       = drv[DRV_W-1:0];
    res.raw_command = cmd[CMD_W-1:0];
    res.height_err  = err[ERR_W-1:0];
    res.target_now  = tgt_height[DRV_W-1:0];
    return res;
  endfunction

  // Write one register and mirror it
  task automatic cfg_write(input cfg_reg_e idx, input int val);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val[CFG_DATA_W-1:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_PROP_GAIN:  p_gain  = int'(val[GAIN_W-1:0]);
      REG_INTEG_GAIN: i_gain  = int'(val[GAIN_W-1:0]);
      REG_DERIV_GAIN: d_gain  = int'(val[GAIN_W-1:0]);
      REG_INTEG_LIM:  acc_lim = int'(val[LIM_W-1:0]);
      REG_STEP_TIME:  tick    = int'(val[GAIN_W-1:0]);
      REG_DRIVE_MID:  mid     = int'(val[DRV_W-1:0]);
      REG_DRIVE_MIN:  dmin    = int'(val[DRV_W-1:0]);
      REG_DRIVE_MAX:  dmax    = int'(val[DRV_W-1:0]);
      default: ;
    endcase
  endtask

  // Offer one item in bursts with random gaps; returns at the negedge after accept
  task automatic send_item(input logic act, input logic dir, input logic [ALT_W-1:0] alt);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gap_max > 0) begin
        s_axis_tvalid = 1'b0;
        repeat ($urandom_range(1, gap_max)) @(negedge clk_i);
      end
    end
    burst_left   = burst_left - 1;
    s_axis_tuser  = act;
    s_axis_tdata  = {{(IN_DATA_W - ALT_W - 1){1'b0}}, alt, dir};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (act == ACT_SAMPLE) begin
      drive_expect_q.push_back(predict_sample(alt));
    end else begin
      step_target(dir);
    end
    @(negedge clk_i);
  endtask

  // Hold input until every result is back, then let the block go quiet
  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (drive_expect_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic int pick_gain();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4);
  endfunction

  // Altitude near the target most of the time, anywhere otherwise
  function automatic logic [ALT_W-1:0] pick_altitude();
    int alt;
    if ($urandom_range(0, 3) == 0) return ALT_W'($urandom_range(0, 255));
    alt = tgt_height + $urandom_range(0, 40) - 20;
    if (alt < 0) alt = 0;
    return alt[ALT_W-1:0];
  endfunction

  // Target clamps at both ends, extreme errors, ignored button fields
  task automatic test_target_limits();
    repeat (6) send_item(ACT_BUTTON, 1'b1, ALT_W'($urandom_range(0, 255)));
    send_item(ACT_SAMPLE, 1'b1, 8'd0);
    repeat (11) send_item(ACT_BUTTON, 1'b0, ALT_W'($urandom_range(0, 255)));
    send_item(ACT_SAMPLE, 1'b0, 8'd255);
    wait_idle();
  endtask

  // A step time of zero acts as one
  task automatic test_zero_step_time();
    cfg_write(REG_STEP_TIME, 0);
    cfg_write(REG_INTEG_GAIN, 2);
    send_item(ACT_SAMPLE, 1'b0, 8'd20);
    send_item(ACT_SAMPLE, 1'b1, 8'd0);
    wait_idle();
  endtask

  // drive_min above drive_max: the result may end above drive_max
  task automatic test_inverted_bounds();
    cfg_write(REG_STEP_TIME, 1);
    cfg_write(REG_DRIVE_MIN, 100);
    cfg_write(REG_DRIVE_MAX, 0);
    send_item(ACT_SAMPLE, 1'b0, 8'd0);
    send_item(ACT_SAMPLE, 1'b0, 8'd200);
    wait_idle();
  endtask

  // Gains, limit and step time at their top, then gains and limit at zero
  task automatic test_extreme_config();
    cfg_write(REG_PROP_GAIN, 255);
    cfg_write(REG_INTEG_GAIN, 255);
    cfg_write(REG_DERIV_GAIN, 255);
    cfg_write(REG_INTEG_LIM, 32767);
    cfg_write(REG_STEP_TIME, 255);
    cfg_write(REG_DRIVE_MID, 100);
    cfg_write(REG_DRIVE_MIN, 0);
    cfg_write(REG_DRIVE_MAX, 100);
    send_item(ACT_SAMPLE, 1'b0, 8'd255);
    send_item(ACT_SAMPLE, 1'b1, 8'd255);
    wait_idle();
    cfg_write(REG_PROP_GAIN, 0);
    cfg_write(REG_INTEG_GAIN, 0);
    cfg_write(REG_DERIV_GAIN, 0);
    cfg_write(REG_INTEG_LIM, 0);
    cfg_write(REG_STEP_TIME, 1);
    cfg_write(REG_DRIVE_MID, 0);
    cfg_write(REG_DRIVE_MAX, 0);
    send_item(ACT_SAMPLE, 1'b0, 8'd0);
    wait_idle();
  endtask

  // Long output stall while items keep coming, so the input backs up
  task automatic test_output_stall();
    cfg_write(REG_PROP_GAIN, 1);
    cfg_write(REG_INTEG_GAIN, 1);
    cfg_write(REG_DERIV_GAIN, 1);
    cfg_write(REG_INTEG_LIM, 200);
    cfg_write(REG_DRIVE_MID, 50);
    cfg_write(REG_DRIVE_MAX, 100);
    gap_max  = 0;
    rdy_mode = RDY_ALWAYS;
    hold_req = 1'b1;
    repeat (30) send_item(ACT_SAMPLE, 1'($urandom_range(0, 1)), pick_altitude());
    wait_idle();
  endtask

  // Random configuration per phase, mixed buttons and samples
  task automatic test_random_traffic();
    int up_bias;
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      cfg_write(REG_PROP_GAIN, pick_gain());
      cfg_write(REG_INTEG_GAIN, pick_gain());
      cfg_write(REG_DERIV_GAIN, pick_gain());
      case ($urandom_range(0, 3))
        0:       cfg_write(REG_INTEG_LIM, 0);
        1:       cfg_write(REG_INTEG_LIM, 32767);
        default: cfg_write(REG_INTEG_LIM, $urandom_range(0, 500));
      endcase
      cfg_write(REG_STEP_TIME, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                                           : $urandom_range(1, 4));
      cfg_write(REG_DRIVE_MID, $urandom_range(0, 100));
      cfg_write(REG_DRIVE_MIN, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 100)
                                                           : $urandom_range(0, 40));
      cfg_write(REG_DRIVE_MAX, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 100)
                                                           : $urandom_range(60, 100));
      gap_max  = (ph % 4 == 0) ? 0 : ((ph % 2 == 1) ? 3 : 20);
      rdy_mode = rdy_mode_e'(ph % 3);
      up_bias  = $urandom_range(20, 80);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 4) == 0) begin
          send_item(ACT_BUTTON, $urandom_range(1, 100) <= up_bias,
                    ALT_W'($urandom_range(0, 255)));
        end else begin
          send_item(ACT_SAMPLE, 1'($urandom_range(0, 1)), pick_altitude());
        end
      end
    end
    wait_idle();
  endtask

  // Result receiver: own stall pattern, plus one long hold on request
  initial begin
    int beat;
    beat          = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      beat = beat + 1;
      case (rdy_mode)
        RDY_RANDOM:  m_axis_tready = ($urandom_range(0, 9) < 7);
        RDY_PATTERN: m_axis_tready = ((beat % 11) < 6);
        default:     m_axis_tready = 1'b1;
      endcase
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    pid_out_t got;
    pid_out_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = pid_out_t'(m_axis_tdata);
      if (drive_expect_q.size() == 0) begin
        fail_count = fail_count + 1;
        if (fail_count <= REPORT_MAX)
          $display("%0t: unexpected result drive=%0d cmd=%0d err=%0d tgt=%0d", $realtime,
                   got.drive, got.raw_command, got.height_err, got.target_now);
      end else begin
        want = drive_expect_q.pop_front();
        if (got.drive !== want.drive || got.raw_command !== want.raw_command ||
            got.height_err !== want.height_err || got.target_now !== want.target_now) begin
          fail_count = fail_count + 1;
          if (fail_count <= REPORT_MAX)
            $display("%0t: mismatch exp drive=%0d cmd=%0d err=%0d tgt=%0d, got %0d %0d %0d %0d",
                     $realtime, want.drive, want.raw_command, want.height_err, want.target_now,
                     got.drive, got.raw_command, got.height_err, got.target_now);
        end
      end
    end
  end

  // Count cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog
  initial begin
    @(posedge rst_ni);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("altitude_pid_with_target_stepping test failed");
    $finish;
  end

  // Main sequence
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_PROP_GAIN;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_BUTTON;
    fail_count    = 0;
    quiet_cycles  = 0;
    burst_left    = 0;
    gap_max       = 4;
    hold_req      = 1'b0;
    rdy_mode      = RDY_RANDOM;
    // reset values of the bench copy
    tgt_height = int'(TARGET_RESET);
    integ_sum  = 0;
    prev_err   = 0;
    p_gain     = int'(PROP_GAIN_RST);
    i_gain     = int'(INTEG_GAIN_RST);
    d_gain     = int'(DERIV_GAIN_RST);
    acc_lim    = int'(INTEG_LIM_RST);
    tick       = int'(STEP_TIME_RST);
    mid        = int'(DRIVE_MID_RST);
    dmin       = int'(DRIVE_MIN_RST);
    dmax       = int'(DRIVE_MAX_RST);
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_target_limits();
    test_zero_step_time();
    test_inverted_bounds();
    test_extreme_config();
    test_output_stall();
    test_random_traffic();

    if (fail_count == 0 && drive_expect_q.size() == 0) begin
      $display("altitude_pid_with_target_stepping test passed");
    end else begin
      $display("altitude_pid_with_target_stepping test failed");
    end
    $finish;
  end

endmodule
